// File: rtl/core/tlpw_pkg.sv
// Shared types and constants for the three-level page walk unit.
`timescale 1ns / 1ps

package tlpw_pkg;

	localparam int unsigned PPN_W         = 44;
	localparam int unsigned VA_W          = 39;
	localparam int unsigned PA_W          = 56;
	localparam int unsigned PTE_W         = 64;
	localparam int unsigned IDX_W         = 9;
	localparam int unsigned OFF_W         = 12;
	localparam int unsigned SLOT_FIELD_W  = 4;
	localparam int unsigned PTE_PPN_LSB   = 10;
	localparam int unsigned ENTRIES_PER_TABLE = 512;
	localparam int unsigned LEVELS        = 3;
	localparam int unsigned CFG_IDX_W     = 1;

	// request types
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_XLATE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
	localparam logic [1:0] ST_OVER_LIMIT = 2'd2;
	localparam logic [1:0] ST_OUTSIDE    = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TABLE_PAGE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE_PAGE = 1'b1;

	typedef struct packed {
		logic                    req_type;
		logic [VA_W-1:0]         virt_addr;
		logic [SLOT_FIELD_W-1:0] table_slot;
		logic [IDX_W-1:0]        entry_index;
		logic [PTE_W-1:0]        entry_value;
	} req_t;

	typedef struct packed {
		logic [PA_W-1:0] phys_addr;
		logic [1:0]      status;
	} resp_t;

	// controller -> datapath
	typedef struct packed {
		logic       clr_we;     // write zero at the clear counter, advance it
		logic       wr_item;    // store the incoming entry word
		logic       capture;    // latch the incoming virtual address
		logic       rd_en;      // issue a table read
		logic       src_root;   // read uses root page and input VA, else last entry read
		logic       rd_leaf;    // walk read targets the leaf level
		logic       push;       // load the output register
		logic       from_pend;  // push takes the held result
		logic       hold;       // park the finished result
		logic [1:0] fin_status;
		logic       fin_phys;   // result carries the translated address
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic req_write;
		logic over_limit;
		logic in_range;
		logic pte_valid;
		logic out_free;
		logic clr_last;
	} ctl_sts_t;

endpackage

// File: rtl/core/tlpw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tlpw_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/tlpw_ctrl.sv
// Walk controller: clearing pass, request decode, level sequencing, result handoff.
`timescale 1ns / 1ps

module tlpw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tlpw_pkg::ctl_sts_t  sts,
	output tlpw_pkg::ctl_cmd_t  cmd
);

	import tlpw_pkg::*;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_WALK  = 2'd2;
	localparam logic [1:0] S_REPLY = 2'd3;

	localparam logic [1:0] LVL_ROOT = 2'd2;
	localparam logic [1:0] LVL_MID  = 2'd1;
	localparam logic [1:0] LVL_LEAF = 2'd0;

	logic [1:0] state_q, state_d;
	logic [1:0] level_q, level_d;
	logic       fin;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		level_d  = level_q;
		fin      = 1'b0;
		in_stall = (state_q != S_IDLE);

		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				// root page and input VA feed the range check and the first read
				cmd.src_root = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					priority if (sts.req_write) begin
						cmd.wr_item    = 1'b1;
						cmd.fin_status = ST_OK;
						fin            = 1'b1;
					end else if (sts.over_limit) begin
						cmd.fin_status = ST_OVER_LIMIT;
						fin            = 1'b1;
					end else if (!sts.in_range) begin
						cmd.fin_status = ST_OUTSIDE;
						fin            = 1'b1;
					end else begin
						cmd.rd_en    = 1'b1;
						level_d      = LVL_ROOT;
						state_d      = S_WALK;
					end
				end
			end
			S_WALK: begin
				// read data holds the entry of level_q
				priority if (!sts.pte_valid) begin
					cmd.fin_status = ST_NOT_FOUND;
					fin            = 1'b1;
				end else if (level_q == LVL_LEAF) begin
					cmd.fin_status = ST_OK;
					cmd.fin_phys   = 1'b1;
					fin            = 1'b1;
				end else if (!sts.in_range) begin
					cmd.fin_status = ST_OUTSIDE;
					fin            = 1'b1;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_leaf = (level_q == LVL_MID);
					level_d     = level_q - 2'd1;
				end
			end
			S_REPLY: begin
				if (sts.out_free) begin
					cmd.push      = 1'b1;
					cmd.from_pend = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// push the result, or park it if the output is stalled (read data may move on later)
		if (fin) begin
			if (sts.out_free) begin
				cmd.push = 1'b1;
				state_d  = S_IDLE;
			end else begin
				cmd.hold = 1'b1;
				state_d  = S_REPLY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			level_q <= LVL_ROOT;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
		end
	end

endmodule

// File: rtl/core/tlpw_dpath.sv
// Walk datapath: config registers, entry store, range check, result registers.
`timescale 1ns / 1ps

module tlpw_dpath #(
	parameter int unsigned TABLE_SLOTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tlpw_pkg::ctl_cmd_t                  cmd,
	output tlpw_pkg::ctl_sts_t                  sts,
	input  tlpw_pkg::req_t                      in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output tlpw_pkg::resp_t                     out_data,
	input  logic                                cfg_we,
	input  logic [tlpw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tlpw_pkg::PPN_W-1:0]          cfg_data
);

	import tlpw_pkg::*;

	localparam int unsigned DEPTH  = TABLE_SLOTS * ENTRIES_PER_TABLE;
	localparam int unsigned AW     = $clog2(DEPTH);
	localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

	logic [PPN_W-1:0] root_q, base_q;
	logic [OFF_W+2*IDX_W-1:0] va_q;
	logic [AW-1:0]    clr_cnt_q;
	logic [PTE_W-1:0] rdata;
	logic [PPN_W-1:0] ppn_src, ppn_diff;
	logic [IDX_W-1:0] idx;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic             wr_en;
	logic [PTE_W-1:0] wr_word;
	logic             slot_ok;
	resp_t            res_direct, pend_q, out_q;
	logic             out_valid_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
			base_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROOT_TABLE_PAGE: root_q <= cfg_data;
				CFG_STORE_BASE_PAGE: base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// table page to slot
	assign ppn_src  = cmd.src_root ? root_q : rdata[PTE_PPN_LSB +: PPN_W];
	assign ppn_diff = ppn_src - base_q;
	assign idx      = cmd.src_root ? in_data.virt_addr[OFF_W+2*IDX_W +: IDX_W]
	                : (cmd.rd_leaf ? va_q[OFF_W +: IDX_W] : va_q[OFF_W+IDX_W +: IDX_W]);
	assign rd_addr  = AW'({ppn_diff[SLOT_W-1:0], idx});

	// store writes: clearing pass or write transaction
	assign slot_ok = (9'(in_data.table_slot) < 9'(TABLE_SLOTS));
	always_comb begin
		if (cmd.clr_we) begin
			wr_addr = clr_cnt_q;
			wr_word = '0;
		end else begin
			wr_addr = AW'({SLOT_W'(in_data.table_slot), in_data.entry_index});
			wr_word = in_data.entry_value;
		end
	end
	assign wr_en = cmd.clr_we | (cmd.wr_item & slot_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_we) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	tlpw_ram #(
		.WIDTH (PTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_word),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			va_q <= in_data.virt_addr[OFF_W+2*IDX_W-1:0];
		end
	end

	// result
	assign res_direct.status    = cmd.fin_status;
	assign res_direct.phys_addr = cmd.fin_phys
		? {rdata[PTE_PPN_LSB +: PPN_W], va_q[OFF_W-1:0]} : '0;

	always_ff @(posedge clk) begin
		if (cmd.hold) begin
			pend_q <= res_direct;
		end
		if (cmd.push) begin
			out_q <= cmd.from_pend ? pend_q : res_direct;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts.req_write  = (in_data.req_type == REQ_WRITE);
	assign sts.over_limit = in_data.virt_addr[VA_W-1];
	assign sts.in_range   = (ppn_src >= base_q) && (ppn_diff < PPN_W'(TABLE_SLOTS));
	assign sts.pte_valid  = rdata[0];
	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.clr_last   = (clr_cnt_q == AW'(DEPTH - 1));

endmodule

// File: rtl/core/three_level_page_walk_unit.sv
// Top level of the three-level page walk unit.
`timescale 1ns / 1ps

// Translates 39-bit virtual addresses through three levels of 512-entry page
// tables held in a local store of TABLE_SLOTS tables, and loads table entries
// through write transactions. After reset the store is swept to zero one entry
// per cycle, with in_stall high; configuration writes are taken throughout. A
// translation holds off the next transaction until it is through: the root
// entry is read in the acceptance cycle and each level's registered store read
// feeds the range check and address of the next, so the three dependent reads
// through the single store read port set the pace. Write transactions and
// translations that fault before the first read are settled on acceptance.
// The output register lets the next transaction in while a result waits; a
// walk that finishes against a stalled output parks its result.

module three_level_page_walk_unit #(
	parameter int unsigned TABLE_SLOTS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  tlpw_pkg::req_t                 in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output tlpw_pkg::resp_t                out_data,
	input  logic                           cfg_we,
	input  logic [tlpw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tlpw_pkg::PPN_W-1:0]     cfg_data
);

	import tlpw_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	tlpw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tlpw_dpath #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

// File: verif/tb_three_level_page_walk_unit.sv
// Self-checking testbench for the three-level page walk unit.
`timescale 1ns / 1ps

module tb_three_level_page_walk_unit;

	import tlpw_pkg::*;

	localparam int unsigned STORE_SLOTS    = 16;
	localparam logic [PPN_W-1:0] PPN_MAX   = {PPN_W{1'b1}};
	localparam int unsigned WATCHDOG_LIMIT = 40000;
	localparam int unsigned HOLD_AT        = 300;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned DRAIN_CYCLES   = 16;

	typedef struct {
		req_t  req;
		bit    known;
		resp_t want;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	req_t             in_data;
	logic             out_valid;
	logic             out_stall;
	resp_t            out_data;
	logic             cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PPN_W-1:0] cfg_data;

	// mirror of the block's state
	logic [PTE_W-1:0] walk_store [0:STORE_SLOTS*ENTRIES_PER_TABLE-1];
	logic [PPN_W-1:0] walk_root;
	logic [PPN_W-1:0] walk_base;

	resp_t            walk_results_due [$];
	logic [VA_W-1:0]  mapped_vas [$];
	dir_row_t         dir_rows [$];
	int unsigned      sent_total;
	int unsigned      mismatches;
	int unsigned      idle_cycles;
	bit               quiet_run;

	three_level_page_walk_unit #(
		.TABLE_SLOTS(STORE_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic resp_t walk_result(req_t r);
		resp_t            res;
		logic [PPN_W-1:0] page;
		logic [PPN_W-1:0] slot_off;
		logic [PTE_W-1:0] entry;
		logic [IDX_W-1:0] idx;
		int               lvl;
		res = '0;
		res.status = ST_OK;
		if (r.req_type == REQ_WRITE) begin
			walk_store[{r.table_slot, r.entry_index}] = r.entry_value;
			return res;
		end
		if (r.virt_addr[VA_W-1]) begin
			res.status = ST_OVER_LIMIT;
			return res;
		end
		page = walk_root;
		for (lvl = LEVELS - 1; lvl >= 0; lvl--) begin
			idx = r.virt_addr[OFF_W + IDX_W*lvl +: IDX_W];
			slot_off = page - walk_base;
			if (page < walk_base || slot_off >= PPN_W'(STORE_SLOTS)) begin
				res.status = ST_OUTSIDE;
				return res;
			end
			entry = walk_store[{slot_off[SLOT_FIELD_W-1:0], idx}];
			if (!entry[0]) begin
				res.status = ST_NOT_FOUND;
				return res;
			end
			page = entry[PTE_PPN_LSB +: PPN_W];
		end
		res.phys_addr = {page, r.virt_addr[OFF_W-1:0]};
		return res;
	endfunction

	function automatic logic [PTE_W-1:0] pte_word(logic [PPN_W-1:0] ppn, logic [9:0] upper,
			logic [8:0] perm, logic v);
		return {upper, ppn, perm, v};
	endfunction

	function automatic logic [VA_W-1:0] va_of(logic [IDX_W-1:0] l2, logic [IDX_W-1:0] l1,
			logic [IDX_W-1:0] l0, logic [OFF_W-1:0] off);
		return {l2, l1, l0, off};
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// unused fields of each transaction carry random junk
	function automatic req_t wr_req(logic [SLOT_FIELD_W-1:0] slot, logic [IDX_W-1:0] idx,
			logic [PTE_W-1:0] val);
		req_t       r;
		logic [63:0] junk;
		junk = rand64();
		r.req_type    = REQ_WRITE;
		r.virt_addr   = junk[VA_W-1:0];
		r.table_slot  = slot;
		r.entry_index = idx;
		r.entry_value = val;
		return r;
	endfunction

	function automatic req_t xl_req(logic [VA_W-1:0] va);
		req_t r;
		r.req_type    = REQ_XLATE;
		r.virt_addr   = va;
		r.table_slot  = SLOT_FIELD_W'($urandom_range(0, 15));
		r.entry_index = IDX_W'($urandom_range(0, 511));
		r.entry_value = rand64();
		return r;
	endfunction

	function automatic dir_row_t mk_row(req_t r, bit known, logic [1:0] st,
			logic [PA_W-1:0] pa);
		dir_row_t row;
		row.req = r;
		row.known = known;
		row.want.phys_addr = pa;
		row.want.status = st;
		return row;
	endfunction

	function automatic int unsigned idle_draw();
		return quiet_run ? 0 : $urandom_range(0, 17);
	endfunction

	task automatic send_item(req_t r, bit known, resp_t typed);
		int unsigned gap;
		resp_t       pred;
		gap = idle_draw();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = walk_result(r);
		walk_results_due.push_back(known ? typed : pred);
		sent_total++;
		if (sent_total % 40 == 0)
			quiet_run = ($urandom_range(0, 4) == 0);
	endtask

	task automatic send_checked(req_t r);
		send_item(r, 1'b0, '0);
	endtask

	task automatic drain_results();
		while (walk_results_due.size() != 0) @(posedge clk);
	endtask

	task automatic set_walk_config(logic [PPN_W-1:0] root, logic [PPN_W-1:0] base);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROOT_TABLE_PAGE;
		cfg_data <= root;
		@(posedge clk);
		cfg_index <= CFG_STORE_BASE_PAGE;
		cfg_data <= base;
		@(posedge clk);
		cfg_we <= 1'b0;
		walk_root = root;
		walk_base = base;
	endtask

	function automatic logic [PPN_W-1:0] outside_page();
		logic [63:0] junk;
		junk = rand64();
		if (walk_base != 0 && $urandom_range(0, 1))
			return walk_base - PPN_W'(1);
		if (walk_base <= PPN_MAX - PPN_W'(STORE_SLOTS))
			return walk_base + PPN_W'(STORE_SLOTS) + PPN_W'(junk[3:0]);
		return junk[PPN_W-1:0];
	endfunction

	// Three entry writes that map one page, then its translation; sometimes one
	// entry is spoiled (invalid, or pointing outside the store).
	task automatic map_and_translate();
		logic [PPN_W-1:0]        reach;
		logic [PPN_W-1:0]        root_off;
		logic [SLOT_FIELD_W-1:0] root_slot, s1, s2;
		logic [IDX_W-1:0]        l2, l1, l0;
		logic [OFF_W-1:0]        off;
		logic [PTE_W-1:0]        e2, e1, e0;
		logic [63:0]             junk;
		logic [VA_W-1:0]         va;
		int unsigned             n, fault, lvl;
		reach = PPN_MAX - walk_base;
		n = (reach >= PPN_W'(STORE_SLOTS - 1)) ? STORE_SLOTS : 32'(reach + PPN_W'(1));
		root_off = walk_root - walk_base;
		if (walk_root >= walk_base && root_off < PPN_W'(STORE_SLOTS))
			root_slot = root_off[SLOT_FIELD_W-1:0];
		else
			root_slot = SLOT_FIELD_W'($urandom_range(0, 15));
		s1 = SLOT_FIELD_W'($urandom_range(0, n - 1));
		s2 = SLOT_FIELD_W'($urandom_range(0, n - 1));
		l2 = IDX_W'($urandom_range(0, 255));
		l1 = IDX_W'($urandom_range(0, 511));
		l0 = IDX_W'($urandom_range(0, 511));
		off = OFF_W'($urandom_range(0, 4095));
		junk = rand64();
		e2 = pte_word(walk_base + PPN_W'(s1), 10'($urandom_range(0, 1023)),
			9'($urandom_range(0, 511)), 1'b1);
		e1 = pte_word(walk_base + PPN_W'(s2), 10'($urandom_range(0, 1023)),
			9'($urandom_range(0, 511)), 1'b1);
		e0 = pte_word(junk[PPN_W-1:0], 10'($urandom_range(0, 1023)),
			9'($urandom_range(0, 511)), 1'b1);
		fault = $urandom_range(0, 9);
		lvl = $urandom_range(0, 2);
		if (fault == 0) begin
			case (lvl)
				0: e0[0] = 1'b0;
				1: e1[0] = 1'b0;
				default: e2[0] = 1'b0;
			endcase
		end else if (fault == 1) begin
			if (lvl == 1)
				e1[PTE_PPN_LSB +: PPN_W] = outside_page();
			else
				e2[PTE_PPN_LSB +: PPN_W] = outside_page();
		end
		send_checked(wr_req(root_slot, l2, e2));
		send_checked(wr_req(s1, l1, e1));
		send_checked(wr_req(s2, l0, e0));
		va = va_of(l2, l1, l0, off);
		send_checked(xl_req(va));
		if (mapped_vas.size() >= 64)
			void'(mapped_vas.pop_front());
		mapped_vas.push_back(va);
	endtask

	task automatic send_noise();
		req_t        r;
		logic [63:0] junk;
		junk = rand64();
		r.req_type    = 1'($urandom_range(0, 1));
		r.virt_addr   = junk[VA_W-1:0];
		r.table_slot  = SLOT_FIELD_W'($urandom_range(0, 15));
		r.entry_index = IDX_W'($urandom_range(0, 511));
		r.entry_value = rand64();
		send_checked(r);
	endtask

	task automatic run_phase(logic [PPN_W-1:0] root, logic [PPN_W-1:0] base, int unsigned count);
		int unsigned      stop_at, pick;
		logic [VA_W-1:0]  va;
		in_valid <= 1'b0;
		drain_results();
		set_walk_config(root, base);
		stop_at = sent_total + count;
		while (sent_total < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				map_and_translate();
			end else if (pick < 75 && mapped_vas.size() != 0) begin
				va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
				va[OFF_W-1:0] = OFF_W'($urandom_range(0, 4095));
				send_checked(xl_req(va));
			end else begin
				send_noise();
			end
		end
	endtask

	task automatic load_directed();
		// reset config: root page 0, store starts at page 0
		dir_rows.push_back(mk_row(xl_req('0), 1'b1, ST_NOT_FOUND, '0));
		dir_rows.push_back(mk_row(xl_req(39'h40_0000_0000), 1'b1, ST_OVER_LIMIT, '0));
		dir_rows.push_back(mk_row(xl_req(39'h7F_FFFF_FFFF), 1'b1, ST_OVER_LIMIT, '0));
		dir_rows.push_back(mk_row(wr_req(4'd0, 9'd0, '0), 1'b1, ST_OK, '0));
		dir_rows.push_back(mk_row(wr_req(4'd0, 9'd255, pte_word(44'd1, 10'h3FF, 9'h1FF, 1'b1)),
			1'b1, ST_OK, '0));
		dir_rows.push_back(mk_row(wr_req(4'd1, 9'd511, pte_word(44'd2, 10'h3FF, 9'h1FF, 1'b1)),
			1'b1, ST_OK, '0));
		dir_rows.push_back(mk_row(wr_req(4'd2, 9'd511, pte_word(PPN_MAX, 10'h3FF, 9'h1FF, 1'b1)),
			1'b1, ST_OK, '0));
		dir_rows.push_back(mk_row(xl_req(39'h3F_FFFF_FFFF), 1'b1, ST_OK, {PA_W{1'b1}}));
		dir_rows.push_back(mk_row(xl_req(39'h3F_FFFF_F000), 1'b0, ST_OK, '0));
		// middle level entry still empty
		dir_rows.push_back(mk_row(xl_req(va_of(9'd255, 9'd0, 9'd0, 12'd0)), 1'b1, ST_NOT_FOUND,
			'0));
		dir_rows.push_back(mk_row(wr_req(4'd1, 9'd0, pte_word(44'd16, 10'h0, 9'h0, 1'b1)),
			1'b1, ST_OK, '0));
		dir_rows.push_back(mk_row(xl_req(va_of(9'd255, 9'd0, 9'd0, 12'd0)), 1'b1, ST_OUTSIDE,
			'0));
		// leaf with every bit set except valid
		dir_rows.push_back(mk_row(wr_req(4'd2, 9'd0, 64'hFFFF_FFFF_FFFF_FFFE), 1'b1, ST_OK, '0));
		dir_rows.push_back(mk_row(xl_req(va_of(9'd255, 9'd511, 9'd0, 12'd0)), 1'b1,
			ST_NOT_FOUND, '0));
		// loop back into the root table
		dir_rows.push_back(mk_row(wr_req(4'd0, 9'd1, pte_word(44'd15, 10'h0, 9'h0, 1'b1)),
			1'b1, ST_OK, '0));
		dir_rows.push_back(mk_row(wr_req(4'd15, 9'd0, pte_word(44'd0, 10'h0, 9'h0, 1'b1)),
			1'b1, ST_OK, '0));
		dir_rows.push_back(mk_row(wr_req(4'd0, 9'd0, 64'h1), 1'b1, ST_OK, '0));
		dir_rows.push_back(mk_row(xl_req(va_of(9'd1, 9'd0, 9'd0, 12'hABC)), 1'b0, ST_OK, '0));
		dir_rows.push_back(mk_row(wr_req(4'd15, 9'd511, {PTE_W{1'b1}}), 1'b1, ST_OK, '0));
		dir_rows.push_back(mk_row(xl_req(va_of(9'd1, 9'd511, 9'd0, 12'd0)), 1'b0, ST_OK, '0));
		dir_rows.push_back(mk_row(xl_req(va_of(9'd1, 9'd0, 9'd511, 12'hFFF)), 1'b0, ST_OK, '0));
	endtask

	// stimulus
	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ROOT_TABLE_PAGE;
		cfg_data <= '0;
		foreach (walk_store[i])
			walk_store[i] = '0;
		walk_root = '0;
		walk_base = '0;
		sent_total = 0;
		quiet_run = 1'b0;
		load_directed();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_rows[i])
			send_item(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want);
		run_phase(44'h105, 44'h100, 250);
		run_phase(PPN_MAX, PPN_MAX - 44'd15, 250);
		run_phase(PPN_MAX, PPN_MAX, 200);
		run_phase('0, '0, 200);
		run_phase(PPN_MAX, '0, 100);
		run_phase(44'd7, 44'd3, 100);
		in_valid <= 1'b0;
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// result side back-pressure, with one long hold-off to fill the block
	initial begin
		int unsigned taken;
		int unsigned w;
		bit          held;
		taken = 0;
		held = 1'b0;
		out_stall <= 1'b0;
		forever begin
			w = idle_draw();
			if (taken == HOLD_AT && !held) begin
				held = 1'b1;
				w = HOLD_CYCLES;
			end
			if (w != 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	always @(posedge clk) begin
		resp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (walk_results_due.size() == 0) begin
				$error("unexpected transaction: phys_addr %h status %0d",
					out_data.phys_addr, out_data.status);
				mismatches++;
			end else begin
				want = walk_results_due.pop_front();
				if (out_data.phys_addr !== want.phys_addr) begin
					$error("phys_addr: expected %h, got %h", want.phys_addr,
						out_data.phys_addr);
					mismatches++;
				end
				if (out_data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_data.status);
					mismatches++;
				end
			end
		end
	end

	// the post-reset clear sweep accepts nothing; the watchdog limit outlasts it
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		mismatches = 0;
		idle_cycles = 0;
	end

endmodule

// File: files.f
rtl/core/tlpw_pkg.sv
rtl/core/tlpw_ram.sv
rtl/core/tlpw_ctrl.sv
rtl/core/tlpw_dpath.sv
rtl/core/three_level_page_walk_unit.sv
verif/tb_three_level_page_walk_unit.sv
